// ===== sv/swa_pkg.sv =====
// ----------------------------------------------------------------------------
// swa_pkg: shared definitions for the sliding window average
// Field widths, the minimum window length and the divider status bundle.
// ----------------------------------------------------------------------------
package swa_pkg;

   localparam int SAMPLE_W   = 24;   // signed Q15.8 sample and mean
   localparam int INTERVAL_W = 16;   // sampling interval register
   localparam int HELD_W     = 11;   // held count field on the result
   localparam int RSP_W      = 40;   // result tdata, padded to whole bytes
   localparam int MIN_WINDOW = 10;   // shortest window in samples

   // Status of the shared divider as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== sv/sliding_window_average.sv =====
// ----------------------------------------------------------------------------
// sliding_window_average: boxcar moving average over a sample ring
// Running sum over the last window_length samples, mean by a shared divider.
// ----------------------------------------------------------------------------
// An accepted item passes through S_READ, S_UPDATE, S_MEAN_START, S_MEAN_WAIT
// and S_FINISH; the serial divider works on TW = 24 + log2(MAX_WINDOW) bits
// (34 at the default). No item is taken while one is in work. A csr write
// divides WINDOW_SECONDS by the interval; a zero interval selects MAX_WINDOW.
// Synchronous reset empties the window and sets the interval to one second;
// the sample ring itself is not cleared, as a slot is written before it is read.
module sliding_window_average #(
   parameter int WINDOW_SECONDS = 28800,
   parameter int MAX_WINDOW     = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input items.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [swa_pkg::SAMPLE_W-1:0]        req_tdata,   // [23:0] sample_value
   // Result items.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [23:0] window_average, [24] window_full, [35:25] held_count, [39:36] zero
   output logic [swa_pkg::RSP_W-1:0]           rsp_tdata,
   // Sampling interval register.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [swa_pkg::INTERVAL_W-1:0]      csr_data
);

   localparam int AW = $clog2(MAX_WINDOW);
   localparam int CW = $clog2(MAX_WINDOW + 1);
   localparam int TW = swa_pkg::SAMPLE_W + AW;
   localparam int VW = (CW > swa_pkg::INTERVAL_W) ? CW : swa_pkg::INTERVAL_W;
   localparam int RESET_LEN = (WINDOW_SECONDS > MAX_WINDOW) ? MAX_WINDOW :
                              ((WINDOW_SECONDS < swa_pkg::MIN_WINDOW) ?
                               swa_pkg::MIN_WINDOW : WINDOW_SECONDS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LEN_START,
      S_LEN_WAIT,
      S_READ,
      S_UPDATE,
      S_MEAN_START,
      S_MEAN_WAIT,
      S_FINISH
   } state_type;

   state_type                     state_ff, state_in;
   logic [swa_pkg::INTERVAL_W-1:0] interval_ff, interval_in;
   logic [CW-1:0]                 len_ff, len_in;
   logic [CW-1:0]                 fill_ff, fill_in;
   logic [AW-1:0]                 oldest_ff, oldest_in;
   logic                          full_ff, full_in;
   logic signed [TW-1:0]          total_ff, total_in;
   logic [CW-1:0]                 held_ff, held_in;
   logic                          neg_ff, neg_in;
   logic signed [swa_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [swa_pkg::RSP_W-1:0]     rsp_data_ff, rsp_data_in;

   // Sample ring.
   logic signed [swa_pkg::SAMPLE_W-1:0] ring_mem [MAX_WINDOW];
   logic signed [swa_pkg::SAMPLE_W-1:0] ring_rd_ff;
   logic                          ring_we;
   logic [AW-1:0]                 ring_addr;

   // Shared divider.
   logic                          div_start;
   logic [TW-1:0]                 div_dividend;
   logic [VW-1:0]                 div_divisor;
   logic [TW-1:0]                 div_quotient;
   swa_pkg::div_status_type       div_status;

   logic signed [TW-1:0]          sample_ext;
   logic signed [TW-1:0]          old_ext;
   logic [TW-1:0]                 total_mag;
   logic [TW-1:0]                 mean_wide;
   logic [CW+swa_pkg::HELD_W-1:0] held_wide;
   logic [CW-1:0]                 fill_next;

   assign sample_ext = {{AW{sample_ff[swa_pkg::SAMPLE_W-1]}}, sample_ff};
   assign old_ext    = {{AW{ring_rd_ff[swa_pkg::SAMPLE_W-1]}}, ring_rd_ff};
   assign total_mag  = total_ff[TW-1] ? TW'(-total_ff) : TW'(total_ff);
   assign mean_wide  = neg_ff ? (~div_quotient + TW'(1)) : div_quotient;
   assign held_wide  = {{swa_pkg::HELD_W{1'b0}}, held_ff};
   assign fill_next  = fill_ff + CW'(1);

   assign ring_addr = full_ff ? oldest_ff : fill_ff[AW-1:0];
   assign ring_we   = (state_ff == S_UPDATE);

   assign div_start    = (state_ff == S_MEAN_START) ||
                         ((state_ff == S_LEN_START) && (interval_ff != '0));
   assign div_dividend = (state_ff == S_MEAN_START) ? total_mag : TW'(WINDOW_SECONDS);
   assign div_divisor  = (state_ff == S_MEAN_START) ? VW'(held_ff) : VW'(interval_ff);

   assign csr_ready  = (state_ff == S_IDLE);
   assign req_tready = (state_ff == S_IDLE) && !csr_valid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   swa_divider #(
      .DIVIDEND_W(TW),
      .DIVISOR_W (VW)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .quotient(div_quotient),
      .status  (div_status)
   );

   always_comb begin
      state_in     = state_ff;
      interval_in  = interval_ff;
      len_in       = len_ff;
      fill_in      = fill_ff;
      oldest_in    = oldest_ff;
      full_in      = full_ff;
      total_in     = total_ff;
      held_in      = held_ff;
      neg_in       = neg_ff;
      sample_in    = sample_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               // A new interval empties the window and recomputes its length.
               interval_in = csr_data;
               fill_in     = '0;
               oldest_in   = '0;
               full_in     = 1'b0;
               total_in    = '0;
               state_in    = S_LEN_START;
            end else if (req_tvalid) begin
               sample_in = req_tdata;
               state_in  = S_READ;
            end
         end
         S_LEN_START: begin
            if (interval_ff == '0) begin
               len_in   = CW'(MAX_WINDOW);
               state_in = S_IDLE;
            end else begin
               state_in = S_LEN_WAIT;
            end
         end
         S_LEN_WAIT: begin
            if (div_status.done) begin
               if (div_quotient < TW'(swa_pkg::MIN_WINDOW)) begin
                  len_in = CW'(swa_pkg::MIN_WINDOW);
               end else if (div_quotient > TW'(MAX_WINDOW)) begin
                  len_in = CW'(MAX_WINDOW);
               end else begin
                  len_in = div_quotient[CW-1:0];
               end
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (full_ff) begin
               total_in  = total_ff - old_ext + sample_ext;
               oldest_in = (CW'(oldest_ff) + CW'(1) == len_ff) ? '0 : oldest_ff + AW'(1);
               held_in   = len_ff;
            end else begin
               total_in = total_ff + sample_ext;
               fill_in  = fill_next;
               held_in  = fill_next;
               if (fill_next >= len_ff) begin
                  full_in = 1'b1;
                  held_in = len_ff;
               end
            end
            state_in = S_MEAN_START;
         end
         S_MEAN_START: begin
            neg_in   = total_ff[TW-1];
            state_in = S_MEAN_WAIT;
         end
         S_MEAN_WAIT: begin
            if (div_status.done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0, held_wide[swa_pkg::HELD_W-1:0], full_ff,
                               mean_wide[swa_pkg::SAMPLE_W-1:0]};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         interval_ff  <= swa_pkg::INTERVAL_W'(1);
         len_ff       <= CW'(RESET_LEN);
         fill_ff      <= '0;
         oldest_ff    <= '0;
         full_ff      <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         interval_ff  <= interval_in;
         len_ff       <= len_in;
         fill_ff      <= fill_in;
         oldest_ff    <= oldest_in;
         full_ff      <= full_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      held_ff     <= held_in;
      neg_ff      <= neg_in;
      sample_ff   <= sample_in;
      rsp_data_ff <= rsp_data_in;
   end

   // The oldest sample is read in the cycle before its replacement is written.
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_addr] <= sample_ff;
      end
      ring_rd_ff <= ring_mem[ring_addr];
   end

   a_ready_divider_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_status.busy)
      else $error("item accepted while the divider is busy");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= len_ff)
      else $error("fill level beyond window length");

   a_full_means_filled: assert property (@(posedge clock) disable iff (reset)
      full_ff |-> (fill_ff == len_ff))
      else $error("window marked full but not filled");

   a_oldest_in_window: assert property (@(posedge clock) disable iff (reset)
      CW'(oldest_ff) < len_ff)
      else $error("oldest slot outside the window");

   a_accept_starts_read: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_READ))
      else $error("accepted item did not start the ring read");

endmodule

// ===== sv/swa_divider.sv =====
// ----------------------------------------------------------------------------
// swa_divider: shared restoring divider
// Unsigned division, one quotient bit per cycle, DIVIDEND_W quotient bits per start.
// A zero divisor yields an all-ones quotient.
// ----------------------------------------------------------------------------
module swa_divider #(
   parameter int DIVIDEND_W = 34,
   parameter int DIVISOR_W  = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DIVIDEND_W-1:0]   dividend,
   input  logic [DIVISOR_W-1:0]    divisor,
   output logic [DIVIDEND_W-1:0]   quotient,
   output swa_pkg::div_status_type status
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  div_ff, div_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // Bring down the next dividend bit and try a subtraction.
   assign shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fits    = (shifted >= {1'b0, div_ff});
   assign diff    = shifted - {1'b0, div_ff};

   always_comb begin
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         quo_in   = dividend;
         rem_in   = '0;
         div_in   = divisor;
         count_in = CNT_W'(DIVIDEND_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in   = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the sliding window average
// Drives samples and interval writes through the stream and csr ports. A
// directed table covers the extremes first, then random phases run over
// short, capped and random windows. Each result is checked against its typed
// table entry or against an in-bench running-sum model of the window.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW_SECONDS = 28800;
   localparam int MAX_WINDOW     = 1024;
   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int DRAIN_CYCLES   = 60;
   localparam int SAMPLE_MAX     = 8388607;
   localparam int SAMPLE_MIN     = -8388608;

   typedef struct packed {
      logic [swa_pkg::SAMPLE_W-1:0] average;
      logic                         full;
      logic [swa_pkg::HELD_W-1:0]   held;
   } window_result_type;

   typedef enum bit {ROW_SAMPLE, ROW_INTERVAL} row_kind_type;

   typedef struct {
      row_kind_type kind;
      int           value;
      bit           typed;
      int           average;
      bit           full;
      int           held;
   } directed_row_type;

   logic                           clock;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [swa_pkg::SAMPLE_W-1:0]   req_tdata = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [swa_pkg::RSP_W-1:0]      rsp_tdata;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [swa_pkg::INTERVAL_W-1:0] csr_data = '0;

   // Window model state.
   logic signed [swa_pkg::SAMPLE_W-1:0] window_samples [MAX_WINDOW];
   int unsigned                oldest_index;
   int unsigned                fill_count;
   bit                         window_is_full;
   longint                     window_total;
   int unsigned                window_len;

   window_result_type expected_averages [$];
   int  mismatches;
   int  samples_sent;
   int  averages_checked;
   int  intervals_written;
   int  cycle_count;
   bit  steady;

   directed_row_type directed_rows [24] = '{
      '{ROW_SAMPLE,   SAMPLE_MAX, 1, SAMPLE_MAX, 0, 1},
      '{ROW_SAMPLE,   SAMPLE_MIN, 1, 0,          0, 2},
      '{ROW_SAMPLE,   0,          1, 0,          0, 3},
      '{ROW_SAMPLE,   -1,         1, 0,          0, 4},
      '{ROW_SAMPLE,   12345,      0, 0,          0, 0},
      '{ROW_INTERVAL, 65535,      0, 0,          0, 0},
      '{ROW_SAMPLE,   SAMPLE_MIN, 1, SAMPLE_MIN, 0, 1},
      '{ROW_SAMPLE,   SAMPLE_MIN, 1, SAMPLE_MIN, 0, 2},
      '{ROW_SAMPLE,   SAMPLE_MIN, 1, SAMPLE_MIN, 0, 3},
      '{ROW_SAMPLE,   SAMPLE_MIN, 1, SAMPLE_MIN, 0, 4},
      '{ROW_SAMPLE,   SAMPLE_MIN, 1, SAMPLE_MIN, 0, 5},
      '{ROW_SAMPLE,   SAMPLE_MIN, 1, SAMPLE_MIN, 0, 6},
      '{ROW_SAMPLE,   SAMPLE_MIN, 1, SAMPLE_MIN, 0, 7},
      '{ROW_SAMPLE,   SAMPLE_MIN, 1, SAMPLE_MIN, 0, 8},
      '{ROW_SAMPLE,   SAMPLE_MIN, 1, SAMPLE_MIN, 0, 9},
      '{ROW_SAMPLE,   SAMPLE_MIN, 1, SAMPLE_MIN, 1, 10},
      '{ROW_SAMPLE,   SAMPLE_MAX, 0, 0,          0, 0},
      '{ROW_SAMPLE,   1,          0, 0,          0, 0},
      '{ROW_INTERVAL, 0,          0, 0,          0, 0},
      '{ROW_SAMPLE,   5,          1, 5,          0, 1},
      '{ROW_SAMPLE,   -7,         1, -1,         0, 2},
      '{ROW_INTERVAL, 2881,       0, 0,          0, 0},
      '{ROW_SAMPLE,   100,        1, 100,        0, 1},
      '{ROW_SAMPLE,   SAMPLE_MAX, 0, 0,          0, 0}
   };

   sliding_window_average #(
      .WINDOW_SECONDS (WINDOW_SECONDS),
      .MAX_WINDOW     (MAX_WINDOW)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned window_length_for(
         input logic [swa_pkg::INTERVAL_W-1:0] interval);
      int unsigned len;
      if (interval == 0) begin
         return MAX_WINDOW;
      end
      len = WINDOW_SECONDS / interval;
      if (len < swa_pkg::MIN_WINDOW) begin
         len = swa_pkg::MIN_WINDOW;
      end
      if (len > MAX_WINDOW) begin
         len = MAX_WINDOW;
      end
      return len;
   endfunction

   function automatic void restart_window(input logic [swa_pkg::INTERVAL_W-1:0] interval);
      window_len     = window_length_for(interval);
      oldest_index   = 0;
      fill_count     = 0;
      window_is_full = 1'b0;
      window_total   = 0;
   endfunction

   // Adds one sample to the modeled window and returns the result it should produce.
   function automatic window_result_type advance_window(
         input logic signed [swa_pkg::SAMPLE_W-1:0] sample);
      window_result_type result;
      int unsigned       slot;
      int unsigned       held;
      longint            mean;
      if (window_is_full) begin
         slot = oldest_index % window_len;
         window_total = window_total - window_samples[slot] + sample;
         window_samples[slot] = sample;
         oldest_index = (slot + 1) % window_len;
      end else begin
         if (fill_count < window_len) begin
            window_samples[fill_count] = sample;
            fill_count++;
            window_total += sample;
         end
         if (fill_count >= window_len) begin
            window_is_full = 1'b1;
         end
      end
      held = window_is_full ? window_len : fill_count;
      mean = window_total / longint'(held);
      result.average = mean[swa_pkg::SAMPLE_W-1:0];
      result.full    = window_is_full;
      result.held    = held[swa_pkg::HELD_W-1:0];
      return result;
   endfunction

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_averages.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_interval(input logic [swa_pkg::INTERVAL_W-1:0] interval);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= interval;
      do @(posedge clock); while (!csr_ready);
      restart_window(interval);
      intervals_written++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_sample(input logic [swa_pkg::SAMPLE_W-1:0] sample, input bit typed,
                              input window_result_type typed_result);
      window_result_type predicted;
      while (!steady && $urandom_range(0, 99) < 15) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      do @(posedge clock); while (!req_tready);
      predicted = advance_window(sample);
      expected_averages.insert(expected_averages.size(), typed ? typed_result : predicted);
      samples_sent++;
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 15);
   end

   always @(posedge clock) begin
      window_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_averages.size() == 0) begin
            $error("result with no expectation waiting: tdata %h", rsp_tdata);
            mismatches++;
         end else begin
            want = expected_averages.pop_front();
            averages_checked++;
            if (rsp_tdata[23:0] !== want.average) begin
               $error("window_average: expected %0d, got %0d",
                      $signed(want.average), $signed(rsp_tdata[23:0]));
               mismatches++;
            end
            if (rsp_tdata[24] !== want.full) begin
               $error("window_full: expected %0d, got %0d", want.full, rsp_tdata[24]);
               mismatches++;
            end
            if (rsp_tdata[35:25] !== want.held) begin
               $error("held_count: expected %0d, got %0d", want.held, rsp_tdata[35:25]);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[sliding_window_average] ERROR");
         $finish;
      end
   end

   initial begin
      window_result_type              typed_result;
      logic [swa_pkg::INTERVAL_W-1:0] interval;
      logic [swa_pkg::SAMPLE_W-1:0]   sample;
      int                             count;
      restart_window(1);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_INTERVAL) begin
            write_interval(directed_rows[i].value[swa_pkg::INTERVAL_W-1:0]);
         end else begin
            typed_result.average = directed_rows[i].average[swa_pkg::SAMPLE_W-1:0];
            typed_result.full    = directed_rows[i].full;
            typed_result.held    = directed_rows[i].held[swa_pkg::HELD_W-1:0];
            send_sample(directed_rows[i].value[swa_pkg::SAMPLE_W-1:0],
                        directed_rows[i].typed, typed_result);
         end
      end

      // Random phases: one long run that fills and wraps the largest window,
      // then windows just inside and outside the caps, then random intervals.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin interval = 0;     count = 1100; end
            1: begin interval = 28;    count = 60;   end
            2: begin interval = 29;    count = 60;   end
            3: begin interval = 2880;  count = 150;  end
            4: begin interval = 65535; count = 150;  end
            default: begin
               interval = $urandom_range(0, 1) ?
                          swa_pkg::INTERVAL_W'($urandom_range(30, 2880)) :
                          swa_pkg::INTERVAL_W'($urandom_range(1, 65535));
               count = 145;
            end
         endcase
         write_interval(interval);
         for (int k = 0; k < count; k++) begin
            steady = (phase == 0) && (k >= 300) && (k < 700);
            if (phase == 3 && k == count / 2) begin
               wait_drained();
            end
            case ($urandom_range(0, 7))
               0:       sample = SAMPLE_MAX[swa_pkg::SAMPLE_W-1:0];
               1:       sample = SAMPLE_MIN[swa_pkg::SAMPLE_W-1:0];
               default: sample = swa_pkg::SAMPLE_W'($urandom);
            endcase
            send_sample(sample, 1'b0, typed_result);
         end
      end
      steady = 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_averages.size() != 0) begin
         $error("%0d expected averages never arrived", expected_averages.size());
         mismatches++;
      end
      $display("Sent %0d samples and checked %0d averages over %0d interval writes,",
               samples_sent, averages_checked, intervals_written);
      $display("including the zero, capped and minimum-length windows and wraparound.");
      if (mismatches == 0) begin
         $display("[sliding_window_average] OK");
      end else begin
         $display("[sliding_window_average] ERROR");
      end
      $finish;
   end

endmodule
